[design/trapezoid_step_profile_generator_defines.svh]
// assertion macros of the step profile generator checker
`ifndef TRAPEZOID_STEP_PROFILE_GENERATOR_DEFINES_SVH
`define TRAPEZOID_STEP_PROFILE_GENERATOR_DEFINES_SVH

// same-cycle implication under synchronous reset
`define TSPG_ASSERT_IMPL(name, clk, rst, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication under synchronous reset
`define TSPG_ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[design/tspg_pkg.sv]
// types, constants and codes of the step profile generator
`default_nettype none

package tspg_pkg;

  localparam int FRAC_BITS = 8;
  localparam int POS_W     = 24;
  localparam int VEL_W     = 24;
  localparam int RATE_W    = 20;
  localparam int SRATE_W   = 16;
  localparam int IV_W      = 20;
  localparam int CFG_W     = 24;
  localparam int CFG_IDX_W = 3;
  localparam int SQ_W      = 2 * VEL_W;

  localparam int MUL_A_W  = 64;
  localparam int MUL_B_W  = 24;
  localparam int MUL_P_W  = MUL_A_W + MUL_B_W;
  localparam int DIV_N_W  = MUL_P_W;
  localparam int DIV_D_W  = 40;
  localparam int SQRT_X_W = 64;
  localparam int SQRT_R_W = SQRT_X_W / 2;

  localparam int TICKS_DEFAULT = 1000000;

  localparam logic [IV_W-1:0]  IV_DONE = {IV_W{1'b1}};
  localparam logic [IV_W-1:0]  IV_MAX  = {{(IV_W-1){1'b1}}, 1'b0};
  localparam logic [VEL_W-1:0] VEL_ONE = VEL_W'(1) << FRAC_BITS;
  localparam logic [POS_W-1:0] CNT_MAX = {POS_W{1'b1}};

  // op codes
  localparam logic [2:0] OP_MOVE    = 3'd0;
  localparam logic [2:0] OP_TICK    = 3'd1;
  localparam logic [2:0] OP_STOP    = 3'd2;
  localparam logic [2:0] OP_ESTOP   = 3'd3;
  localparam logic [2:0] OP_SET_POS = 3'd4;

  // status codes
  localparam logic [1:0] STAT_OK        = 2'd0;
  localparam logic [1:0] STAT_RANGE     = 2'd1;
  localparam logic [1:0] STAT_NO_MOTION = 2'd2;
  localparam logic [1:0] STAT_BUSY      = 2'd3;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_VEL    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ACCEL      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DECEL      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_SRATE  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_IV     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_LEFT       = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_RIGHT      = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_LIMITS_EN  = 3'd7;

  // register reset values
  localparam logic [VEL_W-1:0]   RST_MAX_VEL   = 24'd2560000;
  localparam logic [RATE_W-1:0]  RST_ACCEL     = 20'd20000;
  localparam logic [RATE_W-1:0]  RST_DECEL     = 20'd20000;
  localparam logic [SRATE_W-1:0] RST_MAX_SRATE = 16'd16000;
  localparam logic [IV_W-1:0]    RST_MIN_IV    = 20'd62;
  localparam logic [POS_W-1:0]   RST_LEFT      = 24'h800000;
  localparam logic [POS_W-1:0]   RST_RIGHT     = 24'h7FFFFF;

  typedef struct packed {
    logic [2:0]              op;
    logic signed [POS_W-1:0] target_step;
    logic [VEL_W-1:0]        entry_velocity;
  } tspg_in_t;

  typedef struct packed {
    logic                    step_pulse;
    logic                    move_direction;
    logic                    arm_timer;
    logic [IV_W-1:0]         next_interval_us;
    logic                    moving;
    logic signed [POS_W-1:0] step_position;
    logic [VEL_W-1:0]        velocity_now;
    logic [1:0]              status;
  } tspg_out_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_DECODE,
    ST_MV_VE2,
    ST_MV_VM2,
    ST_MV_UP,
    ST_MV_DN,
    ST_MV_CHECK,
    ST_TR_X,
    ST_TR_MUL,
    ST_TR_DIV,
    ST_TR_SQRT,
    ST_TR_PP,
    ST_TR_UP,
    ST_MV_START,
    ST_NI_SEL,
    ST_NI_SQ,
    ST_NI_RN,
    ST_NI_SQRT,
    ST_NI_DIV,
    ST_SP_SQ,
    ST_SP_DIV,
    ST_FINISH
  } tspg_state_t;

endpackage

`default_nettype wire

[design/trapezoid_step_profile_generator.sv]
// Trapezoidal step profile generator: move planning and per-step interval.
// Requests enter on in_valid/in_stall (op, target_step, entry_velocity); one
// result per request leaves on out_valid/out_stall. Configuration is written
// through cfg_write_en/cfg_index/cfg_data; the user must write it only while
// no request is in flight, as the block itself does not enforce this.
// One request is worked on at a time. The arithmetic runs on three serial
// units: a shift-add multiplier, a restoring divider and a root unit. The
// time an op takes is set by the number of serial unit passes it needs.
// in_stall is high from acceptance until the result is handed to the output
// register; a finished result waits there while out_stall is high, and the
// next request is already taken meanwhile.
// Synchronous reset loads the register defaults, clears position and profile
// state, sets the heading positive and empties the output register.
`default_nettype none

module trapezoid_step_profile_generator import tspg_pkg::*; #(
  parameter int TICKS_PER_SECOND = TICKS_DEFAULT
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cfg_write_en,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_data,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire tspg_in_t             in_data,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output tspg_out_t                 out_data
);

  localparam logic [DIV_N_W-1:0] TICK_NUM =
    DIV_N_W'(64'(TICKS_PER_SECOND)) << FRAC_BITS;

  // configuration
  logic [VEL_W-1:0]        max_velocity;
  logic [RATE_W-1:0]       accel_rate;
  logic [RATE_W-1:0]       decel_rate;
  logic [SRATE_W-1:0]      max_step_rate;
  logic [IV_W-1:0]         min_interval_us;
  logic signed [POS_W-1:0] left_limit;
  logic signed [POS_W-1:0] right_limit;
  logic                    limits_enabled;

  // profile state
  logic [POS_W-1:0] steps_done;
  logic [POS_W-1:0] steps_total;
  logic [POS_W-1:0] ramp_up_steps;
  logic [POS_W-1:0] cruise_steps;
  logic [VEL_W-1:0] start_velocity;
  logic [VEL_W-1:0] peak_velocity;
  logic [VEL_W-1:0] present_velocity;
  logic [POS_W-1:0] position_steps;
  logic             heading;
  logic             busy;

  // request in work and its result fields
  tspg_in_t        item;
  logic            pulse_r;
  logic            arm_r;
  logic [IV_W-1:0] iv_r;
  logic [1:0]      status_r;

  // scratch values
  logic [SQ_W-1:0]     ve2;
  logic [SQ_W-1:0]     vm2;
  logic [31:0]         up_q;
  logic [31:0]         dn_q;
  logic [MUL_A_W-1:0]  x_r;
  logic [VEL_W-1:0]    pk;
  logic [SQ_W-1:0]     sq_r;
  logic [SQRT_R_W-1:0] v_raw;

  tspg_state_t state;
  tspg_state_t state_next;
  logic        launched;

  // serial units
  logic                use_mul, use_div, use_sqrt;
  logic                mul_start, div_start, sqrt_start;
  logic [MUL_A_W-1:0]  mul_a;
  logic [MUL_B_W-1:0]  mul_b;
  logic [MUL_P_W-1:0]  mul_prod;
  logic                mul_done;
  logic [DIV_N_W-1:0]  div_num;
  logic [DIV_D_W-1:0]  div_den;
  logic [DIV_N_W-1:0]  div_quo;
  logic                div_done;
  logic [SQRT_X_W-1:0] sqrt_x;
  logic [SQRT_R_W-1:0] sqrt_root;
  logic                sqrt_done;
  logic                step_done;

  // derived values
  logic [RATE_W-1:0]  a_eff, d_eff;
  logic [DIV_D_W-1:0] den_a, den_d;
  logic [POS_W:0]     pos_diff, pos_diff_abs;
  logic [POS_W-1:0]   total_c;
  logic               lim_bad;
  logic [VEL_W-1:0]   ve_c;
  logic               tick_ok;
  logic [POS_W:0]     done_inc;
  logic [POS_W:0]     edge_cnt;
  logic               in_accel, in_cruise;
  logic [POS_W:0]     m_full;
  logic [VEL_W-1:0]   sel_v;
  logic               x_ge;
  logic [SQRT_X_W-1:0] term;
  logic [VEL_W-1:0]   lim_v, v_cl;
  logic [DIV_N_W-1:0] iv_lo;
  logic [IV_W-1:0]    iv_c;
  logic [32:0]        updn;
  logic [32:0]        stop_t;
  logic [SQ_W-1:0]    pp;

  always_comb begin
    a_eff    = (accel_rate == '0) ? RATE_W'(1) : accel_rate;
    d_eff    = (decel_rate == '0) ? RATE_W'(1) : decel_rate;
    den_a    = DIV_D_W'({a_eff, 17'b0});
    den_d    = DIV_D_W'({d_eff, 17'b0});
    pos_diff = {item.target_step[POS_W-1], item.target_step}
             - {position_steps[POS_W-1], position_steps};
    pos_diff_abs = pos_diff[POS_W] ? (~pos_diff + (POS_W+1)'(1)) : pos_diff;
    total_c  = pos_diff_abs[POS_W] ? CNT_MAX : pos_diff_abs[POS_W-1:0];
    lim_bad  = limits_enabled && ((item.target_step < left_limit) ||
                                  (item.target_step > right_limit));
    ve_c     = (item.entry_velocity < max_velocity) ? item.entry_velocity
                                                    : max_velocity;
    tick_ok  = busy && (steps_done < steps_total);
    done_inc = {1'b0, steps_done} + (POS_W+1)'(1);
    edge_cnt = {1'b0, ramp_up_steps} + {1'b0, cruise_steps};
    in_accel = steps_done < ramp_up_steps;
    in_cruise = {1'b0, steps_done} <= edge_cnt;
    m_full   = {1'b0, steps_done} - edge_cnt;
    sel_v    = in_accel ? start_velocity : peak_velocity;
    x_ge     = x_r >= MUL_A_W'(ve2);
    term     = {mul_prod[46:0], 17'b0};
    lim_v    = {max_step_rate, 8'b0};
    if (v_raw < SQRT_R_W'(VEL_ONE)) begin
      v_cl = VEL_ONE;
    end else if (v_raw > SQRT_R_W'(lim_v)) begin
      v_cl = lim_v;
    end else begin
      v_cl = v_raw[VEL_W-1:0];
    end
    iv_lo    = (div_quo < DIV_N_W'(min_interval_us)) ? DIV_N_W'(min_interval_us)
                                                      : div_quo;
    iv_c     = (iv_lo > DIV_N_W'(IV_MAX)) ? IV_MAX : iv_lo[IV_W-1:0];
    updn     = {1'b0, up_q} + {1'b0, dn_q};
    stop_t   = 33'(steps_done) + {1'b0, div_quo[31:0]};
    pp       = mul_prod[SQ_W-1:0];
  end

  // unit operands per state
  always_comb begin
    use_mul  = 1'b0;
    use_div  = 1'b0;
    use_sqrt = 1'b0;
    mul_a    = '0;
    mul_b    = '0;
    div_num  = '0;
    div_den  = '0;
    sqrt_x   = '0;
    case (state)
      ST_MV_VE2: begin
        use_mul = 1'b1;
        mul_a   = MUL_A_W'(start_velocity);
        mul_b   = start_velocity;
      end
      ST_MV_VM2: begin
        use_mul = 1'b1;
        mul_a   = MUL_A_W'(max_velocity);
        mul_b   = max_velocity;
      end
      ST_MV_UP: begin
        use_div = 1'b1;
        div_num = DIV_N_W'(vm2) - DIV_N_W'(ve2) + DIV_N_W'({a_eff, 16'b0});
        div_den = den_a;
      end
      ST_MV_DN: begin
        use_div = 1'b1;
        div_num = DIV_N_W'(vm2) + DIV_N_W'({d_eff, 16'b0});
        div_den = den_d;
      end
      ST_TR_X: begin
        use_mul = 1'b1;
        mul_a   = MUL_A_W'(steps_total);
        mul_b   = MUL_B_W'(d_eff);
      end
      ST_TR_MUL: begin
        use_mul = 1'b1;
        mul_a   = x_ge ? x_r - MUL_A_W'(ve2) : MUL_A_W'(ve2) - x_r;
        mul_b   = MUL_B_W'(a_eff);
      end
      ST_TR_DIV: begin
        use_div = 1'b1;
        div_num = mul_prod;
        div_den = DIV_D_W'(a_eff) + DIV_D_W'(d_eff);
      end
      ST_TR_SQRT: begin
        use_sqrt = 1'b1;
        sqrt_x   = x_ge ? SQRT_X_W'(ve2) + div_quo[SQRT_X_W-1:0]
                        : SQRT_X_W'(ve2) - div_quo[SQRT_X_W-1:0];
      end
      ST_TR_PP: begin
        use_mul = 1'b1;
        mul_a   = MUL_A_W'(pk);
        mul_b   = pk;
      end
      ST_TR_UP: begin
        use_div = 1'b1;
        div_num = (pp > ve2) ? DIV_N_W'(pp - ve2) : '0;
        div_den = den_a;
      end
      ST_NI_SQ: begin
        use_mul = 1'b1;
        mul_a   = MUL_A_W'(sel_v);
        mul_b   = sel_v;
      end
      ST_NI_RN: begin
        use_mul = 1'b1;
        mul_a   = in_accel ? MUL_A_W'(steps_done) : MUL_A_W'(m_full[POS_W-1:0]);
        mul_b   = in_accel ? MUL_B_W'(a_eff) : MUL_B_W'(d_eff);
      end
      ST_NI_SQRT: begin
        use_sqrt = 1'b1;
        if (in_accel) begin
          sqrt_x = SQRT_X_W'(sq_r) + term;
        end else begin
          sqrt_x = (SQRT_X_W'(sq_r) > term) ? SQRT_X_W'(sq_r) - term : '0;
        end
      end
      ST_NI_DIV: begin
        use_div = 1'b1;
        div_num = TICK_NUM;
        div_den = DIV_D_W'(v_cl);
      end
      ST_SP_SQ: begin
        use_mul = 1'b1;
        mul_a   = MUL_A_W'(present_velocity);
        mul_b   = present_velocity;
      end
      ST_SP_DIV: begin
        use_div = 1'b1;
        div_num = mul_prod;
        div_den = den_d;
      end
      default: ;
    endcase
    mul_start  = use_mul && !launched;
    div_start  = use_div && !launched;
    sqrt_start = use_sqrt && !launched;
    step_done  = (use_mul && mul_done) || (use_div && div_done) ||
                 (use_sqrt && sqrt_done);
    in_stall   = (state != ST_IDLE);
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:     if (in_valid) state_next = ST_DECODE;
      ST_DECODE: begin
        case (item.op)
          OP_MOVE: state_next = (lim_bad || total_c == '0) ? ST_FINISH : ST_MV_VE2;
          OP_TICK: state_next = (tick_ok && done_inc < {1'b0, steps_total})
                                ? ST_NI_SEL : ST_FINISH;
          OP_STOP: state_next = busy ? ST_SP_SQ : ST_FINISH;
          default: state_next = ST_FINISH;
        endcase
      end
      ST_MV_VE2:   if (step_done) state_next = ST_MV_VM2;
      ST_MV_VM2:   if (step_done) state_next = ST_MV_UP;
      ST_MV_UP:    if (step_done) state_next = ST_MV_DN;
      ST_MV_DN:    if (step_done) state_next = ST_MV_CHECK;
      ST_MV_CHECK: state_next = (updn > 33'(steps_total)) ? ST_TR_X : ST_MV_START;
      ST_TR_X:     if (step_done) state_next = ST_TR_MUL;
      ST_TR_MUL:   if (step_done) state_next = ST_TR_DIV;
      ST_TR_DIV:   if (step_done) state_next = ST_TR_SQRT;
      ST_TR_SQRT:  if (step_done) state_next = ST_TR_PP;
      ST_TR_PP:    if (step_done) state_next = ST_TR_UP;
      ST_TR_UP:    if (step_done) state_next = ST_MV_START;
      ST_MV_START: state_next = ST_NI_SEL;
      ST_NI_SEL:   state_next = (!in_accel && in_cruise) ? ST_NI_DIV : ST_NI_SQ;
      ST_NI_SQ:    if (step_done) state_next = ST_NI_RN;
      ST_NI_RN:    if (step_done) state_next = ST_NI_SQRT;
      ST_NI_SQRT:  if (step_done) state_next = ST_NI_DIV;
      ST_NI_DIV:   if (step_done) state_next = ST_FINISH;
      ST_SP_SQ:    if (step_done) state_next = ST_SP_DIV;
      ST_SP_DIV:   if (step_done) state_next = ST_FINISH;
      ST_FINISH:   if (!out_valid || !out_stall) state_next = ST_IDLE;
      default:     state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      launched <= 1'b0;
    end else begin
      state <= state_next;
      if (step_done) begin
        launched <= 1'b0;
      end else if (mul_start || div_start || sqrt_start) begin
        launched <= 1'b1;
      end
    end
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      max_velocity    <= RST_MAX_VEL;
      accel_rate      <= RST_ACCEL;
      decel_rate      <= RST_DECEL;
      max_step_rate   <= RST_MAX_SRATE;
      min_interval_us <= RST_MIN_IV;
      left_limit      <= RST_LEFT;
      right_limit     <= RST_RIGHT;
      limits_enabled  <= 1'b0;
    end else if (cfg_write_en) begin
      case (cfg_index)
        CFG_MAX_VEL:   max_velocity    <= cfg_data[VEL_W-1:0];
        CFG_ACCEL:     accel_rate      <= cfg_data[RATE_W-1:0];
        CFG_DECEL:     decel_rate      <= cfg_data[RATE_W-1:0];
        CFG_MAX_SRATE: max_step_rate   <= cfg_data[SRATE_W-1:0];
        CFG_MIN_IV:    min_interval_us <= cfg_data[IV_W-1:0];
        CFG_LEFT:      left_limit      <= cfg_data[POS_W-1:0];
        CFG_RIGHT:     right_limit     <= cfg_data[POS_W-1:0];
        CFG_LIMITS_EN: limits_enabled  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // datapath and profile state
  always_ff @(posedge clk) begin
    if (rst) begin
      steps_done       <= '0;
      steps_total      <= '0;
      ramp_up_steps    <= '0;
      cruise_steps     <= '0;
      start_velocity   <= '0;
      peak_velocity    <= '0;
      present_velocity <= '0;
      position_steps   <= '0;
      heading          <= 1'b1;
      busy             <= 1'b0;
      out_valid        <= 1'b0;
    end else begin
      if (out_valid && !out_stall && state != ST_FINISH) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (in_valid) begin
            item     <= in_data;
            pulse_r  <= 1'b0;
            arm_r    <= 1'b0;
            iv_r     <= IV_DONE;
            status_r <= STAT_OK;
          end
        end
        ST_DECODE: begin
          case (item.op)
            OP_MOVE: begin
              if (lim_bad) begin
                status_r <= STAT_RANGE;
              end else begin
                busy        <= 1'b0;
                heading     <= !pos_diff[POS_W];
                steps_total <= total_c;
                if (total_c == '0) begin
                  status_r <= STAT_NO_MOTION;
                end
                start_velocity <= ve_c;
              end
            end
            OP_TICK: begin
              if (!tick_ok) begin
                busy <= 1'b0;
              end else begin
                pulse_r        <= 1'b1;
                steps_done     <= done_inc[POS_W-1:0];
                position_steps <= heading ? position_steps + POS_W'(1)
                                          : position_steps - POS_W'(1);
                if (done_inc >= {1'b0, steps_total}) begin
                  busy <= 1'b0;
                end
              end
            end
            OP_ESTOP: busy <= 1'b0;
            OP_SET_POS: begin
              if (busy) begin
                status_r <= STAT_BUSY;
              end else begin
                position_steps <= item.target_step;
              end
            end
            default: ;
          endcase
        end
        ST_MV_VE2: if (step_done) ve2 <= mul_prod[SQ_W-1:0];
        ST_MV_VM2: if (step_done) vm2 <= mul_prod[SQ_W-1:0];
        ST_MV_UP:  if (step_done) up_q <= div_quo[31:0];
        ST_MV_DN:  if (step_done) dn_q <= div_quo[31:0];
        ST_MV_CHECK: begin
          if (updn <= 33'(steps_total)) begin
            ramp_up_steps <= up_q[POS_W-1:0];
            cruise_steps  <= POS_W'(33'(steps_total) - updn);
            peak_velocity <= max_velocity;
          end
        end
        ST_TR_X: if (step_done) x_r <= {mul_prod[46:0], 17'b0};
        ST_TR_SQRT: begin
          if (step_done) begin
            pk <= (sqrt_root > SQRT_R_W'(CNT_MAX)) ? CNT_MAX : sqrt_root[VEL_W-1:0];
          end
        end
        ST_TR_UP: begin
          if (step_done) begin
            ramp_up_steps <= (div_quo[31:0] > 32'(steps_total)) ? steps_total
                                                                : div_quo[POS_W-1:0];
            cruise_steps  <= '0;
            peak_velocity <= pk;
          end
        end
        ST_MV_START: begin
          steps_done       <= '0;
          present_velocity <= start_velocity;
          busy             <= 1'b1;
        end
        ST_NI_SEL: if (!in_accel && in_cruise) v_raw <= SQRT_R_W'(peak_velocity);
        ST_NI_SQ:   if (step_done) sq_r <= mul_prod[SQ_W-1:0];
        ST_NI_SQRT: if (step_done) v_raw <= sqrt_root;
        ST_NI_DIV: begin
          if (step_done) begin
            present_velocity <= v_cl;
            iv_r             <= iv_c;
            arm_r            <= (iv_c != IV_DONE);
          end
        end
        ST_SP_DIV: begin
          if (step_done) begin
            steps_total   <= (stop_t > 33'(CNT_MAX)) ? CNT_MAX : stop_t[POS_W-1:0];
            ramp_up_steps <= steps_done;
            cruise_steps  <= '0;
            peak_velocity <= present_velocity;
          end
        end
        ST_FINISH: begin
          if (!out_valid || !out_stall) begin
            out_valid                 <= 1'b1;
            out_data.step_pulse       <= pulse_r;
            out_data.move_direction   <= heading;
            out_data.arm_timer        <= arm_r;
            out_data.next_interval_us <= arm_r ? iv_r : IV_DONE;
            out_data.moving           <= busy;
            out_data.step_position    <= position_steps;
            out_data.velocity_now     <= present_velocity;
            out_data.status           <= status_r;
          end
        end
        default: ;
      endcase
    end
  end

  tspg_mul u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .prod  (mul_prod),
    .done  (mul_done)
  );

  tspg_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .quo   (div_quo),
    .done  (div_done)
  );

  tspg_sqrt u_sqrt (
    .clk   (clk),
    .rst   (rst),
    .start (sqrt_start),
    .x     (sqrt_x),
    .root  (sqrt_root),
    .done  (sqrt_done)
  );

endmodule

`default_nettype wire

[design/tspg_mul.sv]
// bit-serial shift-add multiplier, one multiplier bit per cycle
`default_nettype none

module tspg_mul import tspg_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  input  wire logic [MUL_A_W-1:0] a,
  input  wire logic [MUL_B_W-1:0] b,
  output logic      [MUL_P_W-1:0] prod,
  output logic                    done
);

  localparam int CNT_W = $clog2(MUL_B_W);

  logic [MUL_A_W-1:0] mcand;
  logic [MUL_A_W-1:0] hi;
  logic [MUL_B_W-1:0] lo;
  logic [CNT_W-1:0]   cnt;
  logic               running;
  logic [MUL_A_W:0]   sum;

  always_comb begin
    sum = {1'b0, hi} + (lo[0] ? {1'b0, mcand} : '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        mcand   <= a;
        hi      <= '0;
        lo      <= b;
        cnt     <= '0;
        running <= 1'b1;
      end else if (running) begin
        hi  <= sum[MUL_A_W:1];
        lo  <= {sum[0], lo[MUL_B_W-1:1]};
        cnt <= cnt + CNT_W'(1);
        if (cnt == CNT_W'(MUL_B_W - 1)) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

  assign prod = {hi, lo};

endmodule

`default_nettype wire

[design/tspg_div.sv]
// restoring divider, one quotient bit per cycle
`default_nettype none

module tspg_div import tspg_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  input  wire logic [DIV_N_W-1:0] num,
  input  wire logic [DIV_D_W-1:0] den,
  output logic      [DIV_N_W-1:0] quo,
  output logic                    done
);

  localparam int CNT_W = $clog2(DIV_N_W);

  logic [DIV_D_W-1:0] dvs;
  logic [DIV_D_W-1:0] rem;
  logic [DIV_N_W-1:0] qr;
  logic [CNT_W-1:0]   cnt;
  logic               running;
  logic [DIV_D_W:0]   rem_s;
  logic [DIV_D_W:0]   rem_d;
  logic               ge;

  always_comb begin
    rem_s = {rem, qr[DIV_N_W-1]};
    ge    = rem_s >= {1'b0, dvs};
    rem_d = rem_s - {1'b0, dvs};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        dvs     <= den;
        rem     <= '0;
        qr      <= num;
        cnt     <= '0;
        running <= 1'b1;
      end else if (running) begin
        rem <= ge ? rem_d[DIV_D_W-1:0] : rem_s[DIV_D_W-1:0];
        qr  <= {qr[DIV_N_W-2:0], ge};
        cnt <= cnt + CNT_W'(1);
        if (cnt == CNT_W'(DIV_N_W - 1)) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

  assign quo = qr;

endmodule

`default_nettype wire

[design/tspg_sqrt.sv]
// floor square root, one root bit (two radicand bits) per cycle
`default_nettype none

module tspg_sqrt import tspg_pkg::*; (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                start,
  input  wire logic [SQRT_X_W-1:0] x,
  output logic      [SQRT_R_W-1:0] root,
  output logic                     done
);

  localparam int CNT_W = $clog2(SQRT_R_W);
  localparam int REM_W = SQRT_R_W + 4;

  logic [SQRT_X_W-1:0] xs;
  logic [REM_W-1:0]    rem;
  logic [CNT_W-1:0]    cnt;
  logic                running;
  logic [REM_W-1:0]    rem_s;
  logic [REM_W-1:0]    trial;
  logic                ge;

  always_comb begin
    rem_s = {rem[REM_W-3:0], xs[SQRT_X_W-1 -: 2]};
    trial = {2'b00, root, 2'b01};
    ge    = rem_s >= trial;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        xs      <= x;
        rem     <= '0;
        root    <= '0;
        cnt     <= '0;
        running <= 1'b1;
      end else if (running) begin
        rem  <= ge ? rem_s - trial : rem_s;
        root <= {root[SQRT_R_W-2:0], ge};
        xs   <= {xs[SQRT_X_W-3:0], 2'b00};
        cnt  <= cnt + CNT_W'(1);
        if (cnt == CNT_W'(SQRT_R_W - 1)) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

endmodule

`default_nettype wire

[design/tspg_checker.sv]
// port-level checks of the step profile generator, bound to the top level
`default_nettype none

`include "trapezoid_step_profile_generator_defines.svh"

module tspg_checker import tspg_pkg::*; (
  input wire logic      clk,
  input wire logic      rst,
  input wire logic      out_valid,
  input wire logic      out_stall,
  input wire tspg_out_t out_data
);

  `TSPG_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && out_stall, out_valid && $stable(out_data), "result changed while stalled")
  `TSPG_ASSERT_IMPL(a_idle_code, clk, rst, out_valid && !out_data.arm_timer, out_data.next_interval_us == IV_DONE, "unarmed result without done code")
  `TSPG_ASSERT_IMPL(a_arm_moving, clk, rst, out_valid && out_data.arm_timer, out_data.moving, "timer armed while not moving")
  `TSPG_ASSERT_IMPL(a_pulse_ok, clk, rst, out_valid && out_data.step_pulse, out_data.status == STAT_OK, "step with error status")

endmodule

bind trapezoid_step_profile_generator tspg_checker u_tspg_checker (.*);

`default_nettype wire

[tb/testbench.sv]
// self-checking testbench of the trapezoid step profile generator
`default_nettype none

module testbench;
  import tspg_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint unsigned PROD_CAP = 64'd1 << 62;
  localparam longint unsigned ONE_Q    = 64'd1 << FRAC_BITS;
  localparam longint unsigned SQ_SCALE = 64'd1 << (2 * FRAC_BITS);
  localparam longint unsigned VEL_SAT  = 64'hFFFFFF;
  localparam logic [2:0] OP_SPARE_LO = 3'd5;
  localparam logic [2:0] OP_SPARE_HI = 3'd7;
  localparam int CYCLE_LIMIT = 8000000;
  localparam int DRAIN_CYCLES = 1000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_write_en = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  tspg_in_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  tspg_out_t out_data;

  always #5 clk = ~clk;

  trapezoid_step_profile_generator u_top (
    .clk(clk), .rst(rst), .cfg_write_en(cfg_write_en), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  // profile predictor state
  longint unsigned cf_maxv, cf_acc, cf_dec, cf_srate, cf_miniv;
  logic signed [POS_W-1:0] cf_left, cf_right;
  bit cf_lim_en;
  longint unsigned pf_done, pf_total, pf_up, pf_cruise, pf_v0, pf_peak, pf_vel;
  logic [POS_W-1:0] pf_pos;
  bit pf_dir, pf_busy;

  tspg_out_t expected_results[$];
  int errors = 0;
  int cycles = 0;

  function automatic longint unsigned sat_mul(longint unsigned a, longint unsigned b);
    if (a == 0) return 0;
    if (b > PROD_CAP / a) return PROD_CAP;
    return (a * b > PROD_CAP) ? PROD_CAP : a * b;
  endfunction

  function automatic longint unsigned floor_sqrt(longint unsigned x);
    longint unsigned r = 0;
    longint unsigned b = 64'd1 << 62;
    while (b > x) b >>= 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic longint unsigned accel_eff();
    return cf_acc != 0 ? cf_acc : 1;
  endfunction

  function automatic longint unsigned decel_eff();
    return cf_dec != 0 ? cf_dec : 1;
  endfunction

  // velocity of the coming step and the interval to it
  function automatic longint unsigned step_interval();
    longint unsigned n = pf_done;
    longint unsigned edge_n = pf_up + pf_cruise;
    longint unsigned v, iv, lim, p2, t;
    if (n < pf_up) begin
      v = floor_sqrt(pf_v0 * pf_v0 + sat_mul(sat_mul(2 * accel_eff(), n), SQ_SCALE));
    end else if (n <= edge_n) begin
      v = pf_peak;
    end else if (n < pf_total) begin
      p2 = pf_peak * pf_peak;
      t = sat_mul(sat_mul(2 * decel_eff(), n - edge_n), SQ_SCALE);
      v = floor_sqrt(p2 > t ? p2 - t : 0);
    end else begin
      pf_busy = 0;
      return IV_DONE;
    end
    lim = cf_srate << FRAC_BITS;
    if (v < ONE_Q) v = ONE_Q;
    else if (v > lim) v = lim;
    pf_vel = v > VEL_SAT ? VEL_SAT : v;
    iv = (longint'(TICKS_DEFAULT) * ONE_Q) / v;
    if (iv < cf_miniv) iv = cf_miniv;
    if (iv > IV_MAX) iv = IV_MAX;
    return iv;
  endfunction

  function automatic void plan_profile(tspg_in_t it, ref logic [1:0] stat, ref bit arm,
                                       ref longint unsigned iv);
    longint signed hop = longint'(it.target_step) - longint'($signed(pf_pos));
    longint unsigned a = accel_eff();
    longint unsigned d = decel_eff();
    longint unsigned total, ve, ve2, vm2, den_a, den_d, up, dn, x, p2, pk, pp;
    if (cf_lim_en && (it.target_step < cf_left || it.target_step > cf_right)) begin
      stat = STAT_RANGE;
      return;
    end
    pf_busy = 0;
    pf_dir = hop >= 0;
    total = hop >= 0 ? hop : -hop;
    if (total > CNT_MAX) total = CNT_MAX;
    pf_total = total;
    if (total == 0) begin
      stat = STAT_NO_MOTION;
      return;
    end
    ve = it.entry_velocity < cf_maxv ? it.entry_velocity : cf_maxv;
    pf_v0 = ve;
    ve2 = ve * ve;
    vm2 = cf_maxv * cf_maxv;
    den_a = 2 * a * SQ_SCALE;
    den_d = 2 * d * SQ_SCALE;
    up = (vm2 - ve2 + den_a / 2) / den_a;
    dn = (vm2 + den_d / 2) / den_d;
    if (up + dn > total) begin
      // triangular: peak where the accel and decel parabolas meet
      x = sat_mul(sat_mul(2 * d, total), SQ_SCALE);
      if (x >= ve2) p2 = ve2 + ((x - ve2) / (a + d)) * a + (((x - ve2) % (a + d)) * a) / (a + d);
      else p2 = ve2 - (((ve2 - x) / (a + d)) * a + (((ve2 - x) % (a + d)) * a) / (a + d));
      pk = floor_sqrt(p2);
      if (pk > VEL_SAT) pk = VEL_SAT;
      pp = pk * pk;
      up = pp > ve2 ? (pp - ve2) / den_a : 0;
      if (up > total) up = total;
      pf_peak = pk;
      pf_up = up;
      pf_cruise = 0;
    end else begin
      pf_up = up;
      pf_cruise = total - up - dn;
      pf_peak = cf_maxv;
    end
    pf_done = 0;
    pf_vel = ve;
    pf_busy = 1;
    iv = step_interval();
    arm = iv != IV_DONE;
  endfunction

  function automatic tspg_out_t predict_result(tspg_in_t it);
    tspg_out_t r;
    logic [1:0] stat = STAT_OK;
    bit pulse = 0;
    bit arm = 0;
    longint unsigned iv = IV_DONE;
    longint unsigned t;
    case (it.op)
      OP_MOVE: plan_profile(it, stat, arm, iv);
      OP_TICK: begin
        if (!pf_busy || pf_done >= pf_total) begin
          pf_busy = 0;
        end else begin
          pulse = 1;
          pf_done++;
          pf_pos = pf_dir ? pf_pos + 1 : pf_pos - 1;
          if (pf_done < pf_total) begin
            iv = step_interval();
            arm = iv != IV_DONE;
          end else begin
            pf_busy = 0;
          end
        end
      end
      OP_STOP: begin
        if (pf_busy) begin
          t = pf_done + (pf_vel * pf_vel) / (2 * decel_eff() * SQ_SCALE);
          pf_total = t > CNT_MAX ? CNT_MAX : t;
          pf_up = pf_done;
          pf_cruise = 0;
          pf_peak = pf_vel;
        end
      end
      OP_ESTOP: pf_busy = 0;
      OP_SET_POS: begin
        if (pf_busy) stat = STAT_BUSY;
        else pf_pos = it.target_step;
      end
      default: ;
    endcase
    r.step_pulse = pulse;
    r.move_direction = pf_dir;
    r.arm_timer = arm;
    r.next_interval_us = arm ? iv[IV_W-1:0] : IV_DONE;
    r.moving = pf_busy;
    r.step_position = pf_pos;
    r.velocity_now = pf_vel[VEL_W-1:0];
    r.status = stat;
    return r;
  endfunction

  // result checker
  always @(posedge clk) begin
    tspg_out_t want;
    if (!rst && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        $error("result with no request outstanding: %h", out_data);
        errors++;
      end else begin
        want = expected_results.pop_front();
        if (out_data.step_pulse !== want.step_pulse) begin
          $error("step_pulse exp %0d got %0d", want.step_pulse, out_data.step_pulse); errors++;
        end
        if (out_data.move_direction !== want.move_direction) begin
          $error("move_direction exp %0d got %0d", want.move_direction,
                 out_data.move_direction); errors++;
        end
        if (out_data.arm_timer !== want.arm_timer) begin
          $error("arm_timer exp %0d got %0d", want.arm_timer, out_data.arm_timer); errors++;
        end
        if (out_data.next_interval_us !== want.next_interval_us) begin
          $error("next_interval_us exp %0d got %0d", want.next_interval_us,
                 out_data.next_interval_us); errors++;
        end
        if (out_data.moving !== want.moving) begin
          $error("moving exp %0d got %0d", want.moving, out_data.moving); errors++;
        end
        if (out_data.step_position !== want.step_position) begin
          $error("step_position exp %0d got %0d", want.step_position,
                 out_data.step_position); errors++;
        end
        if (out_data.velocity_now !== want.velocity_now) begin
          $error("velocity_now exp %0d got %0d", want.velocity_now,
                 out_data.velocity_now); errors++;
        end
        if (out_data.status !== want.status) begin
          $error("status exp %0d got %0d", want.status, out_data.status); errors++;
        end
      end
    end
  end

  // receiver stall pattern: free, random, or mostly held
  int stall_mode = 0;
  int stall_count = 0;
  always @(posedge clk) begin
    if (stall_count == 0) begin
      stall_mode <= $urandom_range(2);
      stall_count <= $urandom_range(20, 400);
    end else begin
      stall_count <= stall_count - 1;
    end
    case (stall_mode)
      1: out_stall <= $urandom_range(1);
      2: out_stall <= $urandom_range(7) != 0;
      default: out_stall <= 1'b0;
    endcase
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("testbench: done, errors");
      $finish;
    end
  end

  int burst_left = 0;

  task automatic send_request(tspg_in_t it, bit typed, tspg_out_t typed_exp);
    tspg_out_t p;
    p = predict_result(it);
    expected_results.push_back(typed ? typed_exp : p);
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (in_stall);
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(3) == 0 ? $urandom_range(50, 300) : $urandom_range(1, 30))
        @(posedge clk);
      burst_left = $urandom_range(1, 25);
    end else begin
      burst_left--;
    end
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    cfg_write_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_write_en <= 1'b0;
    case (idx)
      CFG_MAX_VEL:   cf_maxv = val;
      CFG_ACCEL:     cf_acc = val[RATE_W-1:0];
      CFG_DECEL:     cf_dec = val[RATE_W-1:0];
      CFG_MAX_SRATE: cf_srate = val[SRATE_W-1:0];
      CFG_MIN_IV:    cf_miniv = val[IV_W-1:0];
      CFG_LEFT:      cf_left = val;
      CFG_RIGHT:     cf_right = val;
      CFG_LIMITS_EN: cf_lim_en = val[0];
      default: ;
    endcase
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic load_settings(logic [23:0] maxv, logic [19:0] acc, logic [19:0] dec,
                               logic [15:0] srate, logic [19:0] miniv,
                               logic [23:0] left, logic [23:0] right, bit en);
    wait_idle();
    write_reg(CFG_MAX_VEL, maxv);
    write_reg(CFG_ACCEL, acc);
    write_reg(CFG_DECEL, dec);
    write_reg(CFG_MAX_SRATE, srate);
    write_reg(CFG_MIN_IV, miniv);
    write_reg(CFG_LEFT, left);
    write_reg(CFG_RIGHT, right);
    write_reg(CFG_LIMITS_EN, en);
  endtask

  // target a short hop away (near zero while limits are on) so that moves run through to completion
  function automatic logic [POS_W-1:0] near_target();
    longint signed base = cf_lim_en ? 0 : longint'($signed(pf_pos));
    return base + $urandom_range(0, 80) - 40;
  endfunction

  task automatic random_requests(int count);
    tspg_in_t it;
    int r;
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(99);
      it.entry_velocity = $urandom;
      it.target_step = $urandom;
      if (!pf_busy) begin
        if (r < 80) begin
          it.op = OP_MOVE;
          if (r < 70) it.target_step = near_target();
          if (r < 20) it.entry_velocity = it.entry_velocity >> $urandom_range(0, 23);
        end else if (r < 86) begin
          it.op = OP_SET_POS;
          if (r < 84) it.target_step = near_target();
        end else if (r < 90) it.op = OP_TICK;
        else if (r < 93) it.op = OP_STOP;
        else if (r < 96) it.op = OP_ESTOP;
        else it.op = $urandom_range(OP_SPARE_LO, OP_SPARE_HI);
      end else begin
        if (r < 88) it.op = OP_TICK;
        else if (r < 91) it.op = OP_STOP;
        else if (r < 93) it.op = OP_ESTOP;
        else if (r < 96) begin
          it.op = OP_MOVE;
          it.target_step = near_target();
        end else if (r < 98) it.op = OP_SET_POS;
        else it.op = $urandom_range(OP_SPARE_LO, OP_SPARE_HI);
      end
      send_request(it, 0, '0);
    end
  endtask

  typedef struct {
    logic [2:0]         op;
    logic [POS_W-1:0]   target;
    logic [VEL_W-1:0]   entry;
    bit                 typed;
    tspg_out_t          want;
  } dir_row_t;

  localparam tspg_out_t IDLE_AT_ZERO = '{0, 1, 0, IV_DONE, 0, 24'h0, 24'h0, STAT_OK};
  localparam tspg_out_t IDLE_AT_MIN  = '{0, 1, 0, IV_DONE, 0, 24'h800000, 24'h0, STAT_OK};
  localparam tspg_out_t ZERO_HOP     = '{0, 1, 0, IV_DONE, 0, 24'h800000, 24'h0,
                                         STAT_NO_MOTION};

  dir_row_t dir_table[24] = '{
    '{OP_TICK,     24'h0,      24'h0,      1, IDLE_AT_ZERO},
    '{OP_SET_POS,  24'h800000, 24'h0,      1, IDLE_AT_MIN},
    '{OP_MOVE,     24'h800000, 24'hFFFFFF, 1, ZERO_HOP},
    '{OP_STOP,     24'h0,      24'h0,      1, IDLE_AT_MIN},
    '{OP_ESTOP,    24'h0,      24'h0,      1, IDLE_AT_MIN},
    '{OP_SPARE_LO, 24'h123456, 24'h0,      1, IDLE_AT_MIN},
    '{OP_SPARE_HI, 24'hFFFFFF, 24'hFFFFFF, 1, IDLE_AT_MIN},
    '{OP_MOVE,     24'h7FFFFF, 24'hFFFFFF, 0, '0},
    '{OP_TICK,     24'h0,      24'h0,      0, '0},
    '{OP_SET_POS,  24'h0,      24'h0,      0, '0},
    '{OP_TICK,     24'h0,      24'h0,      0, '0},
    '{OP_STOP,     24'h0,      24'h0,      0, '0},
    '{OP_TICK,     24'h0,      24'h0,      0, '0},
    '{OP_ESTOP,    24'h0,      24'h0,      0, '0},
    '{OP_SET_POS,  24'h0,      24'h0,      0, '0},
    '{OP_MOVE,     24'h3,      24'h0,      0, '0},
    '{OP_TICK,     24'h0,      24'h0,      0, '0},
    '{OP_TICK,     24'h0,      24'h0,      0, '0},
    '{OP_TICK,     24'h0,      24'h0,      0, '0},
    '{OP_TICK,     24'h0,      24'h0,      0, '0},
    '{OP_MOVE,     24'hFFFFFD, 24'h000100, 0, '0},
    '{OP_TICK,     24'h0,      24'h0,      0, '0},
    '{OP_MOVE,     24'h2,      24'h0,      0, '0},
    '{OP_ESTOP,    24'h0,      24'h0,      0, '0}
  };

  initial begin
    tspg_in_t it;
    cf_maxv = RST_MAX_VEL; cf_acc = RST_ACCEL; cf_dec = RST_DECEL;
    cf_srate = RST_MAX_SRATE; cf_miniv = RST_MIN_IV;
    cf_left = RST_LEFT; cf_right = RST_RIGHT; cf_lim_en = 0;
    pf_done = 0; pf_total = 0; pf_up = 0; pf_cruise = 0;
    pf_v0 = 0; pf_peak = 0; pf_vel = 0; pf_pos = '0;
    pf_dir = 1; pf_busy = 0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_table[i]) begin
      it.op = dir_table[i].op;
      it.target_step = dir_table[i].target;
      it.entry_velocity = dir_table[i].entry;
      send_request(it, dir_table[i].typed, dir_table[i].want);
    end
    random_requests(200);

    load_settings(24'hFFFFFF, 20'hFFFFF, 20'hFFFFF, 16'hFFFF, 20'd1,
                  24'h800000, 24'h7FFFFF, 0);
    random_requests(220);
    load_settings(24'd256, 20'd1, 20'd1, 16'd1, 20'd1000000, 24'h800000, 24'h7FFFFF, 0);
    random_requests(200);
    load_settings(24'd2560000, 20'd0, 20'd0, 16'd16000, 20'd62, 24'h800000, 24'h7FFFFF, 0);
    random_requests(200);
    load_settings(24'd800000, 20'd5000, 20'd30000, 16'd3000, 20'd100,
                  -24'sd40, 24'd40, 1);
    random_requests(250);
    load_settings(24'hFFFFFF, 20'd300, 20'd70000, 16'hFFFF, 20'd1,
                  -24'sd100, 24'd25, 1);
    random_requests(250);

    wait_idle();
    if (errors == 0) $display("testbench: done, clean");
    else $display("testbench: done, errors");
    $finish;
  end

endmodule

`default_nettype wire
